FILE: sv/fsk4rx_pkg.sv
package fsk4rx_pkg;

    // Fixed-point format of every signal: signed Q4.20.
    localparam int SIG_W   = 24;
    localparam int FRAC_W  = 20;
    localparam int ACC_W   = 56;
    localparam int MUL_A_W = 27;
    localparam int PROD_W  = MUL_A_W + SIG_W;
    localparam int FIR_TAPS    = 5;
    localparam int SYNC_LENGTH = 8;
    localparam int WIN_W       = 2 * SYNC_LENGTH;

    localparam logic signed [SIG_W-1:0] SIG_ONE = 24'sd1048576;
    localparam logic signed [SIG_W-1:0] SIG_MAX = 24'sh7FFFFF;
    localparam logic signed [SIG_W-1:0] SIG_MIN = 24'sh800000;

    // Filter and loop constants, rounded to Q4.20.
    localparam logic signed [SIG_W-1:0] C_DC_POLE   = 24'sd1043333;
    localparam logic signed [SIG_W-1:0] C_PEAK_DEC  = 24'sd1048471;
    localparam logic signed [SIG_W-1:0] C_TED_GAIN  = 24'sd10486;
    localparam logic signed [SIG_W-1:0] C_TED_KEEP  = 24'sd1038090;
    localparam logic signed [SIG_W-1:0] C_PHASE_ADJ = 24'sd20972;

    // Configuration register indexes.
    localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [2:0] REG_ERROR_LIMIT = 3'd1;
    localparam logic [2:0] REG_LSF_SYNC    = 3'd2;
    localparam logic [2:0] REG_STREAM_SYNC = 3'd3;
    localparam logic [2:0] REG_EOT_SYNC    = 3'd4;

    // Sync match codes.
    localparam logic [1:0] SYNC_NONE   = 2'd0;
    localparam logic [1:0] SYNC_LSF    = 2'd1;
    localparam logic [1:0] SYNC_STREAM = 2'd2;
    localparam logic [1:0] SYNC_EOT    = 2'd3;

    // Divider start and divider result handshake.
    typedef struct packed {
        logic             start;
        logic [SIG_W-1:0] dividend;
        logic [SIG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SIG_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
        logic signed [SIG_W-1:0] r;
        if (v > ACC_W'(SIG_MAX)) begin
            r = SIG_MAX;
        end else if (v < ACC_W'(SIG_MIN)) begin
            r = SIG_MIN;
        end else begin
            r = v[SIG_W-1:0];
        end
        return r;
    endfunction

    // Add one half LSB and floor to the signal grid.
    function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
        return (v + (ACC_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic logic signed [SIG_W-1:0] fir_coef(input logic [2:0] k);
        logic signed [SIG_W-1:0] c;
        case (k)
            3'd0:    c = 24'sd125829;
            3'd1:    c = 24'sd241172;
            3'd2:    c = 24'sd314573;
            3'd3:    c = 24'sd241172;
            3'd4:    c = 24'sd125829;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] mismatches(input logic [WIN_W-1:0] w,
                                              input logic [15:0] p);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < SYNC_LENGTH; i++) begin
            if (w[2*i +: 2] != p[2*i +: 2]) begin
                n = n + 5'd1;
            end
        end
        return n;
    endfunction

endpackage

FILE: sv/fsk4rx_mul.sv
module fsk4rx_mul
    import fsk4rx_pkg::*;
(
    input  logic                       aclk,
    input  logic signed [MUL_A_W-1:0]  mul_a,
    input  logic signed [SIG_W-1:0]    mul_b,
    output logic signed [PROD_W-1:0]   prod_reg
);

    // Shared multiplier with a registered product.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

endmodule

FILE: sv/fsk4rx_div.sv
module fsk4rx_div
    import fsk4rx_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [SIG_W:0]   rem_reg;
    logic [SIG_W-1:0] sh_reg;
    logic [SIG_W-1:0] q_reg;
    logic [SIG_W-1:0] div_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SIG_W:0]   trial;
    logic             fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg[SIG_W-1:0], sh_reg[SIG_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    // The dividend is the magnitude shifted up by the fraction width; its upper
    // bits always stay below the divisor, so 24 steps give the full quotient.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= {{(SIG_W + 1 - (SIG_W - 4)){1'b0}}, req.dividend[SIG_W-1:4]};
                sh_reg   <= {req.dividend[3:0], {(SIG_W - 4){1'b0}}};
                div_reg  <= req.divisor;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
                sh_reg  <= {sh_reg[SIG_W-2:0], 1'b0};
                q_reg   <= {q_reg[SIG_W-2:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SIG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

FILE: sv/fsk4_receive_symbol_recovery_core.sv
// 4FSK receive front end: each audio sample beat is DC-blocked, low-pass
// filtered, level normalized and fed to a symbol timing loop; a result beat
// (symbol code, sync match, strobe value) leaves only on a symbol strobe.
// Each sample is worked through the sequencer states in turn on the single
// shared multiplier, used once per filter tap and loop product, and on the
// 24-step shift-subtract divider, which runs only when the level normalizer
// divides by the running peak; a strobe adds the timing loop states, and the
// core waits in ST_OUT while the previous result still sits in the output
// register. Input ready is high only while the core is idle. A finished
// result sits in the output register while the next sample is already taken.
// Configuration writes are taken at any time but are meant for an idle core.
module fsk4_receive_symbol_recovery_core
    import fsk4rx_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [15:0]      s_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_symbol_code,
    output logic [1:0]              m_sync_kind,
    output logic signed [SIG_W-1:0] m_strobe_value,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [19:0]             cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DC_MUL, ST_DC_ADD, ST_FIR_MUL, ST_FIR_ACC, ST_NORM,
        ST_PEAK_MUL, ST_PEAK, ST_DIV, ST_PHASE, ST_TE_MUL, ST_TE_KEEP,
        ST_TE_SUM, ST_PH_MUL, ST_PH_ADJ, ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [19:0] phase_step_reg;
    logic [3:0]  err_limit_reg;
    logic [15:0] lsf_pat_reg;
    logic [15:0] stream_pat_reg;
    logic [15:0] eot_pat_reg;

    // Signal path state.
    logic signed [SIG_W-1:0] x_reg;
    logic signed [SIG_W-1:0] dc_in_reg;
    logic signed [SIG_W-1:0] dc_out_reg;
    logic signed [SIG_W-1:0] fir_reg [FIR_TAPS];
    logic [2:0]              tap_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SIG_W-1:0] peak_reg;
    logic signed [SIG_W-1:0] phase_reg;
    logic signed [SIG_W-1:0] tea_reg;
    logic signed [SIG_W-1:0] lss_reg;
    logic [1:0]              last_code_reg;
    logic [1:0]              code_reg;
    logic signed [MUL_A_W-1:0] ted_reg;
    logic [WIN_W-1:0]        window_reg;
    logic [3:0]              held_reg;
    logic                    neg_reg;

    // Output register.
    logic                    m_valid_reg;
    logic [1:0]              m_code_reg;
    logic [1:0]              m_kind_reg;
    logic signed [SIG_W-1:0] m_value_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [SIG_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   prod_w;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic signed [SIG_W-1:0] y_next;
    logic signed [SIG_W-1:0] xf_next;
    logic signed [SIG_W-1:0] ax_next;
    logic signed [SIG_W-1:0] peak_next;
    logic signed [SIG_W-1:0] phase_next;
    logic signed [SIG_W-1:0] q_next;
    logic signed [SIG_W-1:0] xs_next;
    logic signed [ACC_W-1:0] x3;
    logic [1:0]              code_next;
    logic signed [MUL_A_W-1:0] ted_next;
    logic [WIN_W-1:0]        window_next;
    logic [1:0]              kind;

    fsk4rx_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    fsk4rx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign prod_w = ACC_W'(prod_reg);

    // Operand select for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DC_MUL: begin
                mul_a = MUL_A_W'(dc_out_reg);
                mul_b = C_DC_POLE;
            end
            ST_FIR_MUL: begin
                mul_a = MUL_A_W'(fir_reg[tap_reg]);
                mul_b = fir_coef(tap_reg);
            end
            ST_PEAK_MUL: begin
                mul_a = MUL_A_W'(peak_reg);
                mul_b = C_PEAK_DEC;
            end
            ST_TE_MUL: begin
                mul_a = ted_reg;
                mul_b = C_TED_GAIN;
            end
            ST_TE_KEEP: begin
                mul_a = MUL_A_W'(tea_reg);
                mul_b = C_TED_KEEP;
            end
            ST_PH_MUL: begin
                mul_a = MUL_A_W'(tea_reg);
                mul_b = C_PHASE_ADJ;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider request: magnitude of the filtered sample over the decayed peak.
    always_comb begin
        div_req.start    = (state_reg == ST_PEAK);
        div_req.dividend = neg_reg ? SIG_W'(-ACC_W'(x_reg)) : x_reg;
        div_req.divisor  = sat_sig(round_frac(prod_w));
    end

    // Datapath arithmetic for the states below.
    always_comb begin
        y_next  = sat_sig(ACC_W'(x_reg) - ACC_W'(dc_in_reg) + round_frac(prod_w));
        xf_next = sat_sig(round_frac(acc_reg));
        ax_next = sat_sig((xf_next < 0) ? -ACC_W'(xf_next) : ACC_W'(xf_next));
        peak_next = (ax_next > peak_reg) ? ax_next : peak_reg;
        phase_next = sat_sig(ACC_W'(phase_reg) + ACC_W'(phase_step_reg));
        q_next = neg_reg ? sat_sig(-ACC_W'(div_rsp.quotient))
                         : sat_sig(ACC_W'(div_rsp.quotient));
        xs_next = x_reg;
        x3 = ACC_W'(x_reg) * 3;
        if (x3 > 2 * ACC_W'(SIG_ONE)) begin
            code_next = 2'd3;
        end else if (x3 > 0) begin
            code_next = 2'd2;
        end else if (x3 > -2 * ACC_W'(SIG_ONE)) begin
            code_next = 2'd1;
        end else begin
            code_next = 2'd0;
        end
        ted_next = ((last_code_reg >= 2'd2) ? MUL_A_W'(x_reg) : -MUL_A_W'(x_reg))
                 - ((code_next >= 2'd2) ? MUL_A_W'(lss_reg) : -MUL_A_W'(lss_reg));
        window_next = {window_reg[WIN_W-3:0], code_reg};
    end

    // Sync match against the window, LSF first.
    always_comb begin
        kind = SYNC_NONE;
        if (held_reg >= 4'(SYNC_LENGTH)) begin
            if (mismatches(window_reg, lsf_pat_reg) <= 5'(err_limit_reg)) begin
                kind = SYNC_LSF;
            end else if (mismatches(window_reg, stream_pat_reg) <= 5'(err_limit_reg)) begin
                kind = SYNC_STREAM;
            end else if (mismatches(window_reg, eot_pat_reg) <= 5'(err_limit_reg)) begin
                kind = SYNC_EOT;
            end
        end
    end

    // Sequencer, configuration and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_step_reg <= 20'd629146;
            err_limit_reg  <= 4'd1;
            lsf_pat_reg    <= 16'd65292;
            stream_pat_reg <= 16'd243;
            eot_pat_reg    <= 16'd65523;
            dc_in_reg      <= '0;
            dc_out_reg     <= '0;
            for (int i = 0; i < FIR_TAPS; i++) begin
                fir_reg[i] <= '0;
            end
            peak_reg       <= '0;
            phase_reg      <= '0;
            tea_reg        <= '0;
            lss_reg        <= '0;
            last_code_reg  <= '0;
            window_reg     <= '0;
            held_reg       <= '0;
            tap_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PHASE_STEP:  phase_step_reg <= cfg_data;
                    REG_ERROR_LIMIT: err_limit_reg  <= cfg_data[3:0];
                    REG_LSF_SYNC:    lsf_pat_reg    <= cfg_data[15:0];
                    REG_STREAM_SYNC: stream_pat_reg <= cfg_data[15:0];
                    REG_EOT_SYNC:    eot_pat_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // A taken result frees the output register unless a new one is loaded.
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= {{3{s_sample[15]}}, s_sample, 5'b0};
                        state_reg <= ST_DC_MUL;
                    end
                end
                ST_DC_MUL: begin
                    state_reg <= ST_DC_ADD;
                end
                ST_DC_ADD: begin
                    dc_in_reg  <= x_reg;
                    dc_out_reg <= y_next;
                    fir_reg[0] <= y_next;
                    for (int i = 1; i < FIR_TAPS; i++) begin
                        fir_reg[i] <= fir_reg[i-1];
                    end
                    acc_reg   <= '0;
                    tap_reg   <= '0;
                    state_reg <= ST_FIR_MUL;
                end
                ST_FIR_MUL: begin
                    state_reg <= ST_FIR_ACC;
                end
                ST_FIR_ACC: begin
                    acc_reg <= acc_reg + prod_w;
                    tap_reg <= tap_reg + 3'd1;
                    state_reg <= (tap_reg == 3'(FIR_TAPS - 1)) ? ST_NORM : ST_FIR_MUL;
                end
                ST_NORM: begin
                    x_reg     <= xf_next;
                    neg_reg   <= xf_next < 0;
                    peak_reg  <= peak_next;
                    state_reg <= (peak_next >= SIG_ONE) ? ST_PEAK_MUL : ST_PHASE;
                end
                ST_PEAK_MUL: begin
                    state_reg <= ST_PEAK;
                end
                ST_PEAK: begin
                    peak_reg  <= div_req.divisor;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        x_reg     <= q_next;
                        state_reg <= ST_PHASE;
                    end
                end
                ST_PHASE: begin
                    if (phase_next < SIG_ONE) begin
                        phase_reg <= phase_next;
                        state_reg <= ST_IDLE;
                    end else begin
                        phase_reg <= phase_next - SIG_ONE;
                        code_reg  <= code_next;
                        ted_reg   <= ted_next;
                        state_reg <= ST_TE_MUL;
                    end
                end
                ST_TE_MUL: begin
                    state_reg <= ST_TE_KEEP;
                end
                ST_TE_KEEP: begin
                    acc_reg   <= prod_w;
                    state_reg <= ST_TE_SUM;
                end
                ST_TE_SUM: begin
                    tea_reg   <= sat_sig(round_frac(acc_reg + prod_w));
                    state_reg <= ST_PH_MUL;
                end
                ST_PH_MUL: begin
                    state_reg <= ST_PH_ADJ;
                end
                ST_PH_ADJ: begin
                    // Pull the phase back by the scaled new timing error average.
                    phase_reg     <= sat_sig(ACC_W'(phase_reg) - round_frac(prod_w));
                    lss_reg       <= xs_next;
                    last_code_reg <= code_reg;
                    window_reg    <= window_next;
                    if (held_reg < 4'(SYNC_LENGTH)) begin
                        held_reg <= held_reg + 4'd1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_code_reg  <= code_reg;
                        m_kind_reg  <= kind;
                        m_value_reg <= x_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_symbol_code  = m_code_reg;
    assign m_sync_kind    = m_kind_reg;
    assign m_strobe_value = m_value_reg;

endmodule

FILE: sv/fsk4rx_chk.sv
module fsk4rx_chk
    import fsk4rx_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic signed [15:0]      s_sample,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [1:0]              m_symbol_code,
    input logic [1:0]              m_sync_kind,
    input logic signed [SIG_W-1:0] m_strobe_value,
    input logic                    cfg_wr_en,
    input logic [2:0]              cfg_index,
    input logic [19:0]             cfg_data
);

    // A result beat holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before acceptance");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_symbol_code) && $stable(m_sync_kind)
                                && $stable(m_strobe_value))
        else $error("result beat changed while stalled");

    // Input ready drops once a sample beat is taken, since the core is then busy with it.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a sample beat");

    // The symbol code must agree with the strobe value thresholds.
    a_slicer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((m_symbol_code == 2'd3) == (m_strobe_value > 24'sd699050))
                  && ((m_symbol_code >= 2'd2) == (m_strobe_value > 24'sd0))
                  && ((m_symbol_code >= 2'd1) == (m_strobe_value > -24'sd699051))))
        else $error("symbol code does not match strobe value");

endmodule

bind fsk4_receive_symbol_recovery_core fsk4rx_chk u_fsk4rx_chk (.*);
